>>> sv/ptt_pkg.sv
// Shared types, codes and helpers for the programmable transition table FSM.
`default_nettype none

package ptt_pkg;

    // Widest state number the block can be built with
    localparam int MAX_STATE_BITS = 16;

    // Item function codes
    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_KEY    = 2'd1;
    localparam logic [1:0] FUNC_FORCE  = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_READ,
        CTL_CHECK
    } ctl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic exec_now;   // handle a non-scan transaction at accept
        logic capture;    // latch key and rewind scan index
        logic read;       // read table entry at scan index
        logic step;       // advance scan index
        logic hit_take;   // take matching entry's destination, post result
        logic miss_done;  // scan ran out, post unmatched result
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic key_op;      // incoming transaction applies a key
        logic table_empty; // no entries stored
        logic hit;         // entry just read matches state and key
        logic last;        // scan index is at the final stored entry
    } dp_status_t;

    // Fold lowercase ASCII letters to uppercase
    function automatic logic [7:0] fold_key(input logic [7:0] k);
        logic [7:0] r;
        r = k;
        if (k >= 8'h61 && k <= 8'h7A)
        begin
            r = k - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/ptt_ctrl.sv
// Sequencing controller: accepts transactions and walks the table scan.
`default_nettype none

module ptt_ctrl
    import ptt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            busy
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (start)
                begin
                    if (status.key_op && !status.table_empty)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = CTL_READ;
                    end
                    else
                    begin
                        cmd.exec_now = 1'b1;
                    end
                end
            end
            CTL_READ:
            begin
                cmd.read   = 1'b1;
                state_next = CTL_CHECK;
            end
            CTL_CHECK:
            begin
                if (status.hit)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = CTL_IDLE;
                end
                else if (status.last)
                begin
                    cmd.miss_done = 1'b1;
                    state_next    = CTL_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = CTL_READ;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != CTL_IDLE);

endmodule

`default_nettype wire

>>> sv/ptt_datapath.sv
// Datapath: transition table memory, entry count, present state and results.
`default_nettype none

module ptt_datapath
    import ptt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int STATE_BITS  = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_cmd_t    cmd,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    input  wire logic [1:0] func,
    input  wire logic [7:0] from_state,
    input  wire logic [7:0] key_byte,
    input  wire logic [7:0] to_state,
    output dp_status_t      status,
    output logic            done,
    output logic [7:0]      current_state,
    output logic            matched,
    output logic            table_overflow
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = 2 * STATE_BITS + 8;

    // Table memory, entries laid out as {from, key, to}
    logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [7:0]            key_reg;
    logic [STATE_BITS-1:0] present_state_reg;
    logic [STATE_BITS-1:0] res_state_reg;
    logic                  done_reg;
    logic                  res_matched_reg;
    logic                  res_overflow_reg;

    logic [MAX_STATE_BITS-1:0] from_wide;
    logic [MAX_STATE_BITS-1:0] to_wide;
    logic [MAX_STATE_BITS-1:0] cfg_wide;
    logic [MAX_STATE_BITS-1:0] res_wide;
    logic [STATE_BITS-1:0]     from_st;
    logic [STATE_BITS-1:0]     to_st;
    logic [STATE_BITS-1:0]     cfg_st;
    logic [STATE_BITS-1:0]     rd_from;
    logic [7:0]                rd_key;
    logic [STATE_BITS-1:0]     rd_to;
    logic                      full;
    logic                      do_append;
    logic                      do_force;

    // Trim incoming state numbers to the state width
    assign from_wide = MAX_STATE_BITS'(from_state);
    assign to_wide   = MAX_STATE_BITS'(to_state);
    assign cfg_wide  = MAX_STATE_BITS'(cfg_data);
    assign from_st   = from_wide[STATE_BITS-1:0];
    assign to_st     = to_wide[STATE_BITS-1:0];
    assign cfg_st    = cfg_wide[STATE_BITS-1:0];

    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_append = cmd.exec_now && (func == FUNC_APPEND) && !full;
    assign do_force  = cmd.exec_now && (func == FUNC_FORCE);

    // Split the entry read out of the table
    assign rd_from = rd_data_reg[ENTRY_W-1 -: STATE_BITS];
    assign rd_key  = rd_data_reg[STATE_BITS +: 8];
    assign rd_to   = rd_data_reg[STATE_BITS-1:0];

    // Status toward the controller
    assign status.key_op      = (func == FUNC_KEY);
    assign status.table_empty = (count_reg == '0);
    assign status.hit         = (rd_from == present_state_reg) && (rd_key == key_reg);
    assign status.last        = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Write appended entries, read at the scan index
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            table_mem[count_reg[IDX_W-1:0]] <= {from_st, key_byte, to_st};
        end
        if (cmd.read)
        begin
            rd_data_reg <= table_mem[idx_reg];
        end
    end

    // Capture the folded key for the scan
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= fold_key(key_byte);
        end
    end

    // Entry count and scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (do_append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // Present state: config load, force, or transition taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_state_reg <= '0;
        end
        else
        begin
            priority if (cfg_we)
            begin
                present_state_reg <= cfg_st;
            end
            else if (do_force)
            begin
                present_state_reg <= to_st;
            end
            else if (cmd.hit_take)
            begin
                present_state_reg <= rd_to;
            end
        end
    end

    // Result registers; done is strobed for one cycle with each result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= 1'b0;
            res_state_reg    <= '0;
            res_matched_reg  <= 1'b0;
            res_overflow_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec_now || cmd.hit_take || cmd.miss_done;
            priority if (cmd.exec_now)
            begin
                res_state_reg    <= do_force ? to_st : present_state_reg;
                res_matched_reg  <= 1'b0;
                res_overflow_reg <= (func == FUNC_APPEND) && full;
            end
            else if (cmd.hit_take)
            begin
                res_state_reg    <= rd_to;
                res_matched_reg  <= 1'b1;
                res_overflow_reg <= 1'b0;
            end
            else if (cmd.miss_done)
            begin
                res_state_reg    <= present_state_reg;
                res_matched_reg  <= 1'b0;
                res_overflow_reg <= 1'b0;
            end
        end
    end

    assign res_wide       = MAX_STATE_BITS'(res_state_reg);
    assign done           = done_reg;
    assign current_state  = res_wide[7:0];
    assign matched        = res_matched_reg;
    assign table_overflow = res_overflow_reg;

    // Entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A taken transition reports a match and the new state
    a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit_take |=> (done_reg && res_matched_reg
                          && res_state_reg == present_state_reg))
        else $error("taken transition not reported");

    // Scan never runs past the stored entries
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> (CNT_W'(idx_reg) < count_reg))
        else $error("scan read beyond stored entries");

    // Overflow flag only on an append into a full table
    a_overflow_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_overflow_reg) |->
            ($past(cmd.exec_now) && $past(func) == FUNC_APPEND && $past(full)))
        else $error("overflow flagged without full append");

endmodule

`default_nettype wire

>>> sv/programmable_transition_table_fsm.sv
// Top level of the programmable transition table state machine.
// Append, force and unused codes, and a key on an empty table, post their result in
// the cycle after start. Any other key transaction scans stored entries in order,
// each by a memory read state, then a compare state, until a match or the last entry.
// Start is taken only while idle, so one scan runs at a time; results cannot stall.
// Reset: entry count and state clear to zero; table contents stay undefined.
`default_nettype none

module programmable_transition_table_fsm
    import ptt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int STATE_BITS  = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] func,
    input  wire logic [7:0] from_state,
    input  wire logic [7:0] key_byte,
    input  wire logic [7:0] to_state,
    output logic            done,
    output logic [7:0]      current_state,
    output logic            matched,
    output logic            table_overflow,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_we;

    // Take configuration writes only when no scan is running
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    ptt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ptt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .STATE_BITS  (STATE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .func           (func),
        .from_state     (from_state),
        .key_byte       (key_byte),
        .to_state       (to_state),
        .status         (status),
        .done           (done),
        .current_state  (current_state),
        .matched        (matched),
        .table_overflow (table_overflow)
    );

endmodule

`default_nettype wire
